FILE: rtl/rtc_pkg.sv
// package for the real-time clock and calendar core
// shared types, limits, input kinds and the gregorian month-length functions
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rtc_pkg;

    // field widths
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int TWELVE_W = 4;

    // limits of the time and date fields
    localparam logic [SECOND_W-1:0] SECOND_MAX = SECOND_W'(59);
    localparam logic [MINUTE_W-1:0] MINUTE_MAX = MINUTE_W'(59);
    localparam logic [HOUR_W-1:0]   HOUR_MAX   = HOUR_W'(23);
    localparam logic [HOUR_W-1:0]   HOUR_NOON  = HOUR_W'(12);
    localparam logic [MONTH_W-1:0]  MONTH_MAX  = MONTH_W'(12);
    localparam logic [YEAR_W-1:0]   YEAR_MIN   = YEAR_W'(1900);
    localparam logic [YEAR_W-1:0]   YEAR_MAX   = YEAR_W'(9999);
    localparam logic [DAY_W-1:0]    DAY_FEB    = DAY_W'(28);
    localparam logic [DAY_W-1:0]    DAY_FEB_LP = DAY_W'(29);
    localparam logic [DAY_W-1:0]    DAY_SHORT  = DAY_W'(30);
    localparam logic [DAY_W-1:0]    DAY_LONG   = DAY_W'(31);

    // divisibility by 25: multiply by the inverse of 25 modulo 2^14, then
    // multiples of 25 land exactly on 0 .. (2^14-1)/25
    localparam logic [YEAR_W-1:0] INV25     = YEAR_W'(7209);
    localparam logic [YEAR_W-1:0] DIV25_MAX = YEAR_W'(((1 << YEAR_W) - 1) / 25);

    // input item kinds
    typedef enum logic [1:0] {
        KIND_TICK      = 2'd0,
        KIND_TICK_TIME = 2'd1,
        KIND_TICK_DATE = 2'd2,
        KIND_LOAD      = 2'd3
    } rtc_kind_t;

    // full time and date
    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } rtc_time_t;

    function automatic logic leap_year(input logic [YEAR_W-1:0] y);
        logic [2*YEAR_W-1:0] prod;
        logic                by25;
        prod = {{YEAR_W{1'b0}}, y} * {{YEAR_W{1'b0}}, INV25};
        by25 = (prod[YEAR_W-1:0] <= DIV25_MAX);
        // by 400: by 16 and by 25; by 4 but not by 100: by 4 and not by 25
        return (by25 && (y[3:0] == 4'd0)) || (!by25 && (y[1:0] == 2'd0));
    endfunction

    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                      input logic [YEAR_W-1:0]  y);
        logic [DAY_W-1:0] len;
        case (m) inside
            4'd2:                   len = leap_year(y) ? DAY_FEB_LP : DAY_FEB;
            4'd4, 4'd6, 4'd9, 4'd11: len = DAY_SHORT;
            default:                len = DAY_LONG;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rtc_calendar_counter_core.sv
// top level of the real-time clock and calendar core
// depends on rtc_pkg, rtc_load_check and rtc_time_step
`timescale 1ns / 1ps
`default_nettype none

//  channel  | ports                 | contents
//  ---------+-----------------------+------------------------------------------
//  input    | s_tvalid/s_tready     | s_tuser kind, s_tdata load fields
//  result   | m_tvalid/m_tready     | m_tdata current time, date, 12-hour view,
//           |                       | load error flag
//
//  one item per cycle sustained while the result side takes its items; an item
//  waits in the input register and its result is registered in the result register
//  the time/date registers update at the moment an item moves from the input
//  register into the result register, so the loop is compare and increment logic
//  plus a mod-25 check by one 14x14 constant multiply
//  reset (aresetn low, synchronous) gives 00:00:00 on 1 january 1900 and empties
//  both registers; a stalled result holds the input register, which then stalls
//  s_tready; the input side still takes an item while a result waits

module rtc_calendar_counter_core
    import rtc_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,

    input  wire         s_tvalid,
    output logic        s_tready,
    // [1:0] kind
    input  wire  [1:0]  s_tuser,
    // [4:0] load_hour, [10:5] load_minute, [16:11] load_second,
    // [21:17] load_day, [25:22] load_month, [39:26] load_year
    input  wire  [39:0] s_tdata,

    output logic        m_tvalid,
    input  wire         m_tready,
    // [4:0] hour_out, [10:5] minute_out, [16:11] second_out, [21:17] day_out,
    // [25:22] month_out, [39:26] year_out, [43:40] hour_twelve, [44] is_pm,
    // [45] load_error, [47:46] zero
    output logic [47:0] m_tdata
);

    // input register
    logic      in_valid_reg;
    rtc_kind_t in_kind_reg;
    rtc_time_t in_load_reg;

    // clock and calendar state
    rtc_time_t cur_time_reg;

    // result register
    logic      out_valid_reg;
    rtc_time_t out_time_reg;
    logic [TWELVE_W-1:0] out_twelve_reg;
    logic      out_pm_reg;
    logic      out_err_reg;

    logic      advance;     // item moves from input register to result register
    logic      load_ok;
    logic      load_error;
    rtc_time_t next_time;
    rtc_time_t s_load;

    // unpack the load fields from the lowest bit up
    always_comb begin
        s_load.hour   = s_tdata[4:0];
        s_load.minute = s_tdata[10:5];
        s_load.second = s_tdata[16:11];
        s_load.day    = s_tdata[21:17];
        s_load.month  = s_tdata[25:22];
        s_load.year   = s_tdata[39:26];
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    rtc_load_check u_load_check (
        .load_time (in_load_reg),
        .load_ok   (load_ok)
    );

    rtc_time_step u_time_step (
        .cur_time   (cur_time_reg),
        .kind       (in_kind_reg),
        .load_time  (in_load_reg),
        .load_ok    (load_ok),
        .next_time  (next_time),
        .load_error (load_error)
    );

    // control and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            cur_time_reg.second <= '0;
            cur_time_reg.minute <= '0;
            cur_time_reg.hour   <= '0;
            cur_time_reg.day    <= DAY_W'(1);
            cur_time_reg.month  <= MONTH_W'(1);
            cur_time_reg.year   <= YEAR_MIN;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                cur_time_reg  <= next_time;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg <= rtc_kind_t'(s_tuser);
            in_load_reg <= s_load;
        end
        if (advance) begin
            out_time_reg   <= next_time;
            out_twelve_reg <= (next_time.hour > HOUR_NOON) ?
                              TWELVE_W'(next_time.hour - HOUR_NOON) :
                              TWELVE_W'(next_time.hour);
            out_pm_reg     <= (next_time.hour >= HOUR_NOON);
            out_err_reg    <= load_error;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_err_reg, out_pm_reg, out_twelve_reg,
                       out_time_reg.year, out_time_reg.month, out_time_reg.day,
                       out_time_reg.second, out_time_reg.minute, out_time_reg.hour};

endmodule

`default_nettype wire

FILE: rtl/rtc_load_check.sv
// range check of a load item, day checked against the loaded month and year
// depends on rtc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rtc_load_check
    import rtc_pkg::*;
(
    input  wire rtc_time_t load_time,
    output logic           load_ok
);

    always_comb begin
        load_ok = (load_time.hour <= HOUR_MAX) &&
                  (load_time.minute <= MINUTE_MAX) &&
                  (load_time.second <= SECOND_MAX) &&
                  (load_time.month != '0) && (load_time.month <= MONTH_MAX) &&
                  (load_time.year >= YEAR_MIN) && (load_time.year <= YEAR_MAX) &&
                  (load_time.day != '0) &&
                  (load_time.day <= month_length(load_time.month, load_time.year));
    end

endmodule

`default_nettype wire

FILE: rtl/rtc_time_step.sv
// next time and date for one item: second tick, day tick or checked load
// depends on rtc_pkg
`timescale 1ns / 1ps
`default_nettype none

module rtc_time_step
    import rtc_pkg::*;
(
    input  wire rtc_time_t cur_time,
    input  wire rtc_kind_t kind,
    input  wire rtc_time_t load_time,
    input  wire            load_ok,
    output rtc_time_t      next_time,
    output logic           load_error
);

    rtc_time_t sec_time;   // time after one second, date untouched
    logic      midnight;   // second tick wrapped past 23:59:59
    rtc_time_t day_time;   // date after one day, time untouched

    always_comb begin
        sec_time = cur_time;
        midnight = 1'b0;
        if (cur_time.second < SECOND_MAX) begin
            sec_time.second = cur_time.second + SECOND_W'(1);
        end else begin
            sec_time.second = '0;
            if (cur_time.minute < MINUTE_MAX) begin
                sec_time.minute = cur_time.minute + MINUTE_W'(1);
            end else begin
                sec_time.minute = '0;
                if (cur_time.hour < HOUR_MAX) begin
                    sec_time.hour = cur_time.hour + HOUR_W'(1);
                end else begin
                    sec_time.hour = '0;
                    midnight      = 1'b1;
                end
            end
        end
    end

    always_comb begin
        day_time = cur_time;
        if (cur_time.day < month_length(cur_time.month, cur_time.year)) begin
            day_time.day = cur_time.day + DAY_W'(1);
        end else begin
            day_time.day = DAY_W'(1);
            if (cur_time.month < MONTH_MAX) begin
                day_time.month = cur_time.month + MONTH_W'(1);
            end else begin
                day_time.month = MONTH_W'(1);
                // year saturates at the top of the range
                if (cur_time.year < YEAR_MAX) begin
                    day_time.year = cur_time.year + YEAR_W'(1);
                end
            end
        end
    end

    always_comb begin
        next_time  = cur_time;
        load_error = 1'b0;
        unique case (kind)
            KIND_TICK: begin
                next_time = sec_time;
                if (midnight) begin
                    next_time.day   = day_time.day;
                    next_time.month = day_time.month;
                    next_time.year  = day_time.year;
                end
            end
            KIND_TICK_TIME: begin
                next_time = sec_time;
            end
            KIND_TICK_DATE: begin
                next_time = day_time;
            end
            KIND_LOAD: begin
                if (load_ok) begin
                    next_time = load_time;
                end else begin
                    load_error = 1'b1;
                end
            end
            default: begin
                next_time = cur_time;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// self-checking testbench for rtc_calendar_counter_core: streams ticks and loads
// through the core and checks every result item against a behavioral calendar
// depends on rtc_pkg and rtc_calendar_counter_core
`timescale 1ns / 1ps
`default_nettype none

module testbench;
    import rtc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1650;
    localparam int DRAIN_CYCLES = 10;

    // one input item: kind plus the six load fields
    typedef struct {
        rtc_kind_t kind;
        rtc_time_t load;
    } clock_item_t;

    // one result item as the core reports it
    typedef struct {
        rtc_time_t             now;
        logic [TWELVE_W-1:0]   hour12;
        logic                  pm;
        logic                  load_err;
    } clock_reading_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    // [1:0] kind
    logic [1:0]  s_tuser  = '0;
    // [4:0] load_hour, [10:5] load_minute, [16:11] load_second,
    // [21:17] load_day, [25:22] load_month, [39:26] load_year
    logic [39:0] s_tdata  = '0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    // [4:0] hour_out, [10:5] minute_out, [16:11] second_out, [21:17] day_out,
    // [25:22] month_out, [39:26] year_out, [43:40] hour_twelve, [44] is_pm,
    // [45] load_error, [47:46] zero
    wire  [47:0] m_tdata;

    clock_item_t    items_pending[$];
    clock_reading_t readings_due[$];
    rtc_time_t      calendar_now;
    int             mismatch_count = 0;
    int             burst_left     = 1;
    int             gap_left       = 0;
    int             stall_mode     = 0;
    int unsigned    stall_tick     = 0;

    rtc_calendar_counter_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // behavioral calendar
    // ------------------------------------------------------------------

    function automatic bit is_leap(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned days_in(input int unsigned m, input int unsigned y);
        case (m)
            2:           return is_leap(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    // next day; the year sticks at its maximum while day and month wrap
    task automatic roll_date();
        if (calendar_now.day < days_in(32'(calendar_now.month), 32'(calendar_now.year))) begin
            calendar_now.day = calendar_now.day + DAY_W'(1);
        end else begin
            calendar_now.day = DAY_W'(1);
            if (calendar_now.month < MONTH_MAX) begin
                calendar_now.month = calendar_now.month + MONTH_W'(1);
            end else begin
                calendar_now.month = MONTH_W'(1);
                if (calendar_now.year < YEAR_MAX)
                    calendar_now.year = calendar_now.year + YEAR_W'(1);
            end
        end
    endtask

    // apply one item to the calendar and return what the core should report
    task automatic step_calendar(input clock_item_t it, output clock_reading_t rd);
        logic midnight;
        midnight    = 1'b0;
        rd.load_err = 1'b0;
        case (it.kind)
            KIND_TICK, KIND_TICK_TIME: begin
                if (calendar_now.second != SECOND_MAX) begin
                    calendar_now.second = calendar_now.second + SECOND_W'(1);
                end else begin
                    calendar_now.second = '0;
                    if (calendar_now.minute != MINUTE_MAX) begin
                        calendar_now.minute = calendar_now.minute + MINUTE_W'(1);
                    end else begin
                        calendar_now.minute = '0;
                        if (calendar_now.hour != HOUR_MAX) begin
                            calendar_now.hour = calendar_now.hour + HOUR_W'(1);
                        end else begin
                            calendar_now.hour = '0;
                            midnight = 1'b1;
                        end
                    end
                end
                // only the full tick carries midnight into the date
                if (it.kind == KIND_TICK && midnight)
                    roll_date();
            end
            KIND_TICK_DATE: roll_date();
            default: begin
                if (it.load.hour <= HOUR_MAX && it.load.minute <= MINUTE_MAX &&
                    it.load.second <= SECOND_MAX &&
                    it.load.month >= 1 && it.load.month <= MONTH_MAX &&
                    it.load.year >= YEAR_MIN && it.load.year <= YEAR_MAX &&
                    it.load.day >= 1 &&
                    it.load.day <= days_in(32'(it.load.month), 32'(it.load.year)))
                    calendar_now = it.load;
                else
                    rd.load_err = 1'b1;
            end
        endcase
        rd.now    = calendar_now;
        rd.hour12 = TWELVE_W'((calendar_now.hour > HOUR_NOON) ?
                              calendar_now.hour - HOUR_NOON : calendar_now.hour);
        rd.pm     = (calendar_now.hour >= HOUR_NOON);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------

    function automatic rtc_time_t stamp(input int unsigned h, input int unsigned mi,
                                        input int unsigned s, input int unsigned d,
                                        input int unsigned mo, input int unsigned y);
        rtc_time_t t;
        t.hour   = HOUR_W'(h);
        t.minute = MINUTE_W'(mi);
        t.second = SECOND_W'(s);
        t.day    = DAY_W'(d);
        t.month  = MONTH_W'(mo);
        t.year   = YEAR_W'(y);
        return t;
    endfunction

    task automatic push_load(input rtc_time_t t);
        clock_item_t it;
        it.kind = KIND_LOAD;
        it.load = t;
        items_pending.push_back(it);
    endtask

    // ticks carry random load fields, which the core must ignore
    task automatic push_tick(input rtc_kind_t k);
        clock_item_t it;
        it.kind = k;
        it.load = stamp($urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63),
                        $urandom_range(0, 31), $urandom_range(0, 15),
                        $urandom_range(0, 16383));
        items_pending.push_back(it);
    endtask

    // ------------------------------------------------------------------
    // sender: bursts of random length with random gaps between them
    // ------------------------------------------------------------------

    always @(posedge aclk) begin : item_driver
        clock_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0 || items_pending.size() == 0) begin
                if (gap_left > 0)
                    gap_left--;
                s_tvalid <= 1'b0;
            end else begin
                nxt = items_pending.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.kind;
                s_tdata  <= {nxt.load.year, nxt.load.month, nxt.load.day,
                             nxt.load.second, nxt.load.minute, nxt.load.hour};
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 15)
                                                            : $urandom_range(0, 3);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver stall pattern, prediction on input accept, result check
    // ------------------------------------------------------------------

    always @(posedge aclk) begin : result_monitor
        clock_item_t    taken;
        clock_reading_t want;
        clock_reading_t got;
        if (!aresetn) begin
            calendar_now       = '0;
            calendar_now.day   = DAY_W'(1);
            calendar_now.month = MONTH_W'(1);
            calendar_now.year  = YEAR_MIN;
            readings_due.delete();
            m_tready <= 1'b0;
        end else begin
            // stall pattern picks its style at random from these:
            // always ready, coin flip, low when the tick count is a multiple of three, long runs
            stall_tick++;
            if (stall_tick % 64 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= (stall_tick % 3 != 0);
                default: m_tready <= ($urandom_range(0, 9) == 0) ? !m_tready : m_tready;
            endcase

            if (s_tvalid && s_tready) begin
                taken.kind        = rtc_kind_t'(s_tuser);
                taken.load.hour   = s_tdata[4:0];
                taken.load.minute = s_tdata[10:5];
                taken.load.second = s_tdata[16:11];
                taken.load.day    = s_tdata[21:17];
                taken.load.month  = s_tdata[25:22];
                taken.load.year   = s_tdata[39:26];
                step_calendar(taken, want);
                readings_due.push_back(want);
            end

            if (m_tvalid && m_tready) begin
                got.now.hour   = m_tdata[4:0];
                got.now.minute = m_tdata[10:5];
                got.now.second = m_tdata[16:11];
                got.now.day    = m_tdata[21:17];
                got.now.month  = m_tdata[25:22];
                got.now.year   = m_tdata[39:26];
                got.hour12     = m_tdata[43:40];
                got.pm         = m_tdata[44];
                got.load_err   = m_tdata[45];
                if (readings_due.size() == 0) begin
                    $error("result item with no expectation pending");
                    mismatch_count++;
                end else begin
                    want = readings_due.pop_front();
                    check_field("hour_out",    16'(want.now.hour),   16'(got.now.hour));
                    check_field("minute_out",  16'(want.now.minute), 16'(got.now.minute));
                    check_field("second_out",  16'(want.now.second), 16'(got.now.second));
                    check_field("day_out",     16'(want.now.day),    16'(got.now.day));
                    check_field("month_out",   16'(want.now.month),  16'(got.now.month));
                    check_field("year_out",    16'(want.now.year),   16'(got.now.year));
                    check_field("hour_twelve", 16'(want.hour12),     16'(got.hour12));
                    check_field("is_pm",       16'(want.pm),         16'(got.pm));
                    check_field("load_error",  16'(want.load_err),   16'(got.load_err));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------

    initial begin : stimulus
        rtc_time_t   t;
        rtc_kind_t   run_kind;
        int unsigned len;
        int unsigned run;

        // ticks of every kind straight out of reset
        push_tick(KIND_TICK);
        push_tick(KIND_TICK_TIME);
        push_tick(KIND_TICK_DATE);
        // last second of the last year: year holds, day and month wrap
        push_load(stamp(23, 59, 59, 31, 12, 9999));
        push_tick(KIND_TICK);
        // time-only tick at midnight keeps the date
        push_load(stamp(23, 59, 59, 28, 2, 2100));
        push_tick(KIND_TICK_TIME);
        // 2100 is not a leap year, so feb 28 rolls to mar 1
        push_tick(KIND_TICK_DATE);
        push_load(stamp(12, 0, 0, 29, 2, 2000));
        push_tick(KIND_TICK_DATE);
        push_load(stamp(13, 30, 30, 29, 2, 2024));
        // feb 29 outside leap years, day 31 in a 30-day month
        push_load(stamp(1, 2, 3, 29, 2, 1900));
        push_load(stamp(1, 2, 3, 29, 2, 2023));
        push_load(stamp(1, 2, 3, 31, 4, 2023));
        push_load(stamp(0, 0, 0, 30, 4, 1900));
        // each field just outside its range, then all ones and all zeros
        push_load(stamp(24, 10, 10, 10, 10, 2000));
        push_load(stamp(10, 60, 10, 10, 10, 2000));
        push_load(stamp(10, 10, 60, 10, 10, 2000));
        push_load(stamp(10, 10, 10, 0, 10, 2000));
        push_load(stamp(10, 10, 10, 10, 13, 2000));
        push_load(stamp(10, 10, 10, 10, 10, 1899));
        push_load(stamp(31, 63, 63, 31, 15, 16383));
        push_load(stamp(0, 0, 0, 0, 0, 0));
        // noon crossing flips the 12-hour view
        push_load(stamp(11, 59, 59, 31, 1, 1900));
        push_tick(KIND_TICK);

        // random part: mostly a boundary-heavy load followed by a run of ticks
        while (items_pending.size() < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise: any kind, any bits
                if ($urandom_range(0, 1) == 0)
                    push_tick(rtc_kind_t'($urandom_range(0, 3)));
                else
                    push_load(stamp($urandom_range(0, 31), $urandom_range(0, 63),
                                    $urandom_range(0, 63), $urandom_range(0, 31),
                                    $urandom_range(0, 15), $urandom_range(0, 16383)));
                continue;
            end

            case ($urandom_range(0, 5))
                0:       t.year = YEAR_MAX;
                1:       t.year = YEAR_MIN;
                2:       t.year = YEAR_W'($urandom_range(475, 2499) * 4);
                3:       t.year = YEAR_W'($urandom_range(19, 99) * 100);
                default: t.year = YEAR_W'($urandom_range(1900, 9999));
            endcase
            if ($urandom_range(0, 2) == 0)
                t.month = ($urandom_range(0, 1) == 0) ? MONTH_W'(2) : MONTH_MAX;
            else
                t.month = MONTH_W'($urandom_range(1, 12));
            len = days_in(32'(t.month), 32'(t.year));
            case ($urandom_range(0, 3))
                0:       t.day = DAY_W'(len);
                1:       t.day = DAY_W'(len - 1);
                2:       t.day = DAY_W'(1);
                default: t.day = DAY_W'($urandom_range(1, len));
            endcase
            t.hour   = ($urandom_range(0, 1) == 0) ? HOUR_MAX : HOUR_W'($urandom_range(0, 23));
            t.minute = ($urandom_range(0, 1) == 0) ? MINUTE_MAX
                                                   : MINUTE_W'($urandom_range(0, 59));
            t.second = ($urandom_range(0, 1) == 0) ? SECOND_MAX
                                                   : SECOND_W'($urandom_range(0, 59));

            // a broken load: one field pushed out of its range
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 5))
                    0: t.hour   = HOUR_W'($urandom_range(24, 31));
                    1: t.minute = MINUTE_W'($urandom_range(60, 63));
                    2: t.second = SECOND_W'($urandom_range(60, 63));
                    3: t.day    = (len == 31 || $urandom_range(0, 1) == 0) ? DAY_W'(0)
                                  : DAY_W'($urandom_range(len + 1, 31));
                    4: t.month  = ($urandom_range(0, 1) == 0) ? MONTH_W'(0)
                                  : MONTH_W'($urandom_range(13, 15));
                    default: t.year = ($urandom_range(0, 1) == 0)
                                      ? YEAR_W'($urandom_range(0, 1899))
                                      : YEAR_W'($urandom_range(10000, 16383));
                endcase
            end
            push_load(t);

            // tick run, mostly of one kind; long date runs cross months and years
            run      = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
            run_kind = rtc_kind_t'($urandom_range(0, 2));
            repeat (run) begin
                if ($urandom_range(0, 3) != 0)
                    push_tick(run_kind);
                else
                    push_tick(rtc_kind_t'($urandom_range(0, 2)));
            end
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (items_pending.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (readings_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && readings_due.size() == 0)
            $display("[rtc_calendar_counter_core] OK");
        else
            $display("[rtc_calendar_counter_core] ERROR");
        $finish;
    end

    // watchdog
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("[rtc_calendar_counter_core] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
